// ----- sv/sxfb_pkg.sv -----
// sxfb_pkg: screen geometry, store sizes, item kinds, controller states and
// the constant wrap tables of the sprite xor framebuffer
// no dependencies
package sxfb_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int CW = XW + 1;
    localparam int LW = $clog2(SCREEN_HEIGHT);
    localparam int SW = LW + 2;

    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_MISC,
        ST_CLEAR
    } t_state;

    typedef logic [XW-1:0] t_xmod_tab [256];
    typedef logic [LW-1:0] t_ymod_tab [256];

    function automatic t_xmod_tab f_build_xmod();
        t_xmod_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = XW'(i % SCREEN_WIDTH);
        end
        return tab;
    endfunction

    function automatic t_ymod_tab f_build_ymod();
        t_ymod_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = LW'(i % SCREEN_HEIGHT);
        end
        return tab;
    endfunction

    localparam t_xmod_tab XMOD_TAB = f_build_xmod();
    localparam t_ymod_tab YMOD_TAB = f_build_ymod();

endpackage

// ----- sv/sprite_xor_framebuffer_unit.sv -----
// sprite_xor_framebuffer_unit: monochrome framebuffer with xor sprite rows,
// collision flag and shadow-compared byte reads, held in two internal memories
// depends on sxfb_pkg
//
// After reset the block holds busy high while it zeroes both memories of
// STORE_BYTES entries (256 at 64x32). An item is taken when start is high and
// busy is low, and its single result shows on the o_ ports for one cycle,
// marked by o_done, in the cycle where busy drops again; the receiver cannot
// stall it. A draw row is split over three byte slots (column byte, next byte,
// wrapped byte 0), each read and, if its mask is not zero, written back
// through the frame memory's one read and one write port, with the next read
// issued while the previous byte is written. A clear zeroes both memories
// again, one memory entry per cycle.
module sprite_xor_framebuffer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [3:0] i_row_index,
    input  logic [7:0] i_sprite_row,
    input  logic       i_first_row,
    input  logic [7:0] i_read_index,
    output logic       busy,
    output logic       o_done,
    output logic       o_collision,
    output logic [7:0] o_read_data,
    output logic       o_changed
);
    import sxfb_pkg::*;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_cnt, n_cnt;
    logic [1:0]     r_slot, n_slot;
    logic           r_flag, n_flag;
    logic           r_done, n_done;
    logic [7:0]     r_rdata, n_rdata;
    logic           r_changed, n_changed;

    logic [XW-1:0]  r_xmod;
    logic [LW-1:0]  r_line;
    logic [7:0]     r_pix;
    logic [AW-1:0]  r_ridx;
    logic           r_rd_ok;

    logic [7:0]     frame_mem [STORE_BYTES];
    logic [7:0]     shadow_mem [STORE_BYTES];
    logic [7:0]     r_frame_q, r_shadow_q;

    logic           fr_we, sh_we;
    logic [AW-1:0]  fr_ra, fr_wa, sh_ra, sh_wa;
    logic [7:0]     fr_wd, sh_wd;

    logic           accept;
    logic [XW-1:0]  xmod_in;
    logic [SW-1:0]  ysum, ysum1, ysum2;

    logic [CW-1:0]  b0, b_hi;
    logic [7:0]     m_lo, m_hi, m_wrap;
    logic [AW-1:0]  line_base;
    logic [AW-1:0]  slot_addr [4];
    logic [7:0]     slot_mask [4];
    logic [1:0]     wslot;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    assign o_done      = r_done;
    assign o_collision = r_flag;
    assign o_read_data = r_rdata;
    assign o_changed   = r_changed;

    // wrap of the incoming coordinates
    assign xmod_in = XMOD_TAB[i_x_pos];
    assign ysum    = SW'(YMOD_TAB[i_y_pos]) + SW'(i_row_index);
    assign ysum1   = (ysum  >= SW'(SCREEN_HEIGHT)) ? ysum  - SW'(SCREEN_HEIGHT) : ysum;
    assign ysum2   = (ysum1 >= SW'(SCREEN_HEIGHT)) ? ysum1 - SW'(SCREEN_HEIGHT) : ysum1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xmod  <= xmod_in;
            r_line  <= LW'(ysum2);
            r_pix   <= i_sprite_row;
            r_ridx  <= AW'(i_read_index);
            r_rd_ok <= (32'(i_read_index) < STORE_BYTES);
        end
    end

    // split the sprite row over low byte, next byte and wrapped byte 0
    always_comb begin : slot_calc
        logic [CW-1:0] c;
        logic [CW-1:0] cw;
        logic          wrap;
        b0     = CW'(r_xmod) >> 3;
        b_hi   = ((b0 + CW'(1)) < CW'(ROW_BYTES)) ? b0 + CW'(1) : '0;
        m_lo   = '0;
        m_hi   = '0;
        m_wrap = '0;
        for (int i = 0; i < 8; i++) begin
            c    = CW'(r_xmod) + CW'(i);
            wrap = (c >= CW'(SCREEN_WIDTH));
            cw   = wrap ? c - CW'(SCREEN_WIDTH) : c;
            if (r_pix[3'(7 - i)]) begin
                if (wrap) begin
                    m_wrap[cw[2:0]] = 1'b1;
                end else if ((cw >> 3) == b0) begin
                    m_lo[cw[2:0]] = 1'b1;
                end else begin
                    m_hi[cw[2:0]] = 1'b1;
                end
            end
        end
        line_base    = AW'(32'(r_line) * ROW_BYTES);
        slot_addr[0] = line_base + AW'(b0);
        slot_mask[0] = m_lo | ((b0 == '0) ? m_wrap : 8'h00);
        slot_addr[1] = line_base + AW'(b_hi);
        slot_mask[1] = m_hi;
        slot_addr[2] = line_base;
        slot_mask[2] = (b0 == '0) ? 8'h00 : m_wrap;
        slot_addr[3] = line_base;
        slot_mask[3] = 8'h00;
    end

    assign wslot = r_slot - 2'd1;

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            frame_mem[fr_wa] <= fr_wd;
        end
        r_frame_q <= frame_mem[fr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            shadow_mem[sh_wa] <= sh_wd;
        end
        r_shadow_q <= shadow_mem[sh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_slot  <= '0;
            r_flag  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_flag  <= n_flag;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata   <= n_rdata;
        r_changed <= n_changed;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_flag    = r_flag;
        n_done    = 1'b0;
        n_rdata   = r_rdata;
        n_changed = r_changed;
        fr_we     = 1'b0;
        fr_ra     = slot_addr[r_slot];
        fr_wa     = slot_addr[wslot];
        fr_wd     = r_frame_q ^ slot_mask[wslot];
        sh_we     = 1'b0;
        sh_ra     = AW'(i_read_index);
        sh_wa     = r_ridx;
        sh_wd     = r_frame_q;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                fr_we = 1'b1;
                fr_wa = r_cnt;
                fr_wd = 8'h00;
                sh_we = 1'b1;
                sh_wa = r_cnt;
                sh_wd = 8'h00;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(STORE_BYTES - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                    if (r_state == ST_CLEAR) begin
                        n_done    = 1'b1;
                        n_rdata   = 8'h00;
                        n_changed = 1'b0;
                    end
                end
            end
            ST_IDLE: begin
                fr_ra = AW'(i_read_index);
                if (start) begin
                    unique case (t_kind'(i_kind))
                        KIND_DRAW: begin
                            n_state = ST_DRAW;
                            n_slot  = '0;
                            if (i_first_row) begin
                                n_flag = 1'b0;
                            end
                        end
                        KIND_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_cnt   = '0;
                        end
                        KIND_READ: n_state = ST_READ;
                        KIND_NONE: n_state = ST_MISC;
                    endcase
                end
            end
            ST_DRAW: begin
                if (r_slot != 2'd0) begin
                    fr_we = (slot_mask[wslot] != 8'h00);
                    if ((r_frame_q & slot_mask[wslot]) != 8'h00) begin
                        n_flag = 1'b1;
                    end
                end
                n_slot = r_slot + 2'd1;
                if (r_slot == 2'd3) begin
                    n_slot    = '0;
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_rdata   = 8'h00;
                    n_changed = 1'b0;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_rd_ok) begin
                    sh_we     = 1'b1;
                    n_rdata   = r_frame_q;
                    n_changed = (r_frame_q != r_shadow_q);
                end else begin
                    n_rdata   = 8'h00;
                    n_changed = 1'b0;
                end
            end
            ST_MISC: begin
                n_state   = ST_IDLE;
                n_done    = 1'b1;
                n_rdata   = 8'h00;
                n_changed = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/sxfb_checker.sv -----
// sxfb_checker: port-level checks on the sprite xor framebuffer unit, bound
// to the top level
// depends on sxfb_pkg and sprite_xor_framebuffer_unit
module sxfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic [1:0] i_kind,
    input logic       busy,
    input logic       o_done,
    input logic [7:0] o_read_data,
    input logic       o_changed
);
    import sxfb_pkg::*;

    // a transfer always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after transfer");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_READ) |=> ##1 o_done)
        else $error("read result not on time");

    // draw result once the draw slots are through, with no read data
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_DRAW) |=>
            ##4 (o_done && !o_changed && o_read_data == 8'h00))
        else $error("draw result not on time or not clean");

endmodule

bind sprite_xor_framebuffer_unit sxfb_checker u_sxfb_checker (.*);
